### design/matrix4_multiply_macros.svh
// Assertion macros shared by the matrix multiply modules.
`ifndef MATRIX4_MULTIPLY_MACROS_SVH
`define MATRIX4_MULTIPLY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define M4M_CHECK_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("m4m same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define M4M_CHECK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("m4m next-cycle check failed");

`endif

### design/m4m_pkg.sv
`default_nettype none

package m4m_pkg;

    localparam int DIM     = 4;
    localparam int NELEM   = DIM * DIM;
    localparam int DATA_W  = 32;
    localparam int FRAC_W  = DATA_W / 2;
    localparam int IDX_W   = 4;
    localparam int ROW_W   = $clog2(DIM);
    localparam int ACT_W   = 2;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int HALF_W  = PROD_W + 1;
    localparam int SUM_W   = PROD_W + 2;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [ACT_W-1:0] ACT_LOAD_LEFT  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_RIGHT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE       = 2'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NELEM - 1);

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

    typedef logic signed [DATA_W-1:0] t_data;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [IDX_W-1:0] index;
        t_data            value;
    } t_cmd;

endpackage

`default_nettype wire

### design/m4m_if.sv
`default_nettype none

interface m4m_in_if;
    logic                          valid;
    logic                          ready;
    logic [m4m_pkg::ACT_W-1:0]     action;
    logic [m4m_pkg::IDX_W-1:0]     elem_index;
    logic signed [m4m_pkg::DATA_W-1:0] elem_value;

    modport source (output valid, action, elem_index, elem_value, input ready);
    modport sink   (input valid, action, elem_index, elem_value, output ready);
endinterface

interface m4m_out_if;
    logic                          valid;
    logic                          ready;
    logic [m4m_pkg::IDX_W-1:0]     out_index;
    logic signed [m4m_pkg::DATA_W-1:0] out_value;
    logic                          out_last;

    modport source (output valid, out_index, out_value, out_last, input ready);
    modport sink   (input valid, out_index, out_value, out_last, output ready);
endinterface

`default_nettype wire

### design/m4m_front.sv
`default_nettype none
`include "matrix4_multiply_macros.svh"

module m4m_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    m4m_in_if.sink           i_in,
    output m4m_pkg::t_cmd    o_cmd,
    output logic             o_cmd_valid,
    input  wire logic        i_cmd_ready
);

    m4m_pkg::t_cmd r_q [m4m_pkg::QDEPTH];
    logic [m4m_pkg::QPTR_W-1:0] r_wptr, r_rptr;
    logic [m4m_pkg::QCNT_W-1:0] r_count;
    logic accept, push, pop;

    assign i_in.ready  = (r_count != m4m_pkg::QCNT_W'(m4m_pkg::QDEPTH));
    assign accept      = i_in.valid && i_in.ready;
    // The unused action code is taken and dropped here.
    assign push        = accept && (i_in.action != m4m_pkg::ACT_NONE);
    assign o_cmd_valid = (r_count != '0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= '{action: i_in.action, index: i_in.elem_index,
                             value: i_in.elem_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `M4M_CHECK_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= m4m_pkg::QCNT_W'(m4m_pkg::QDEPTH))
    `M4M_CHECK_NEXT(a_push_grows, i_clk, i_rst_n, push && !pop, r_count == $past(r_count) + 1'b1)

endmodule

`default_nettype wire

### design/m4m_back.sv
`default_nettype none
`include "matrix4_multiply_macros.svh"

module m4m_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire m4m_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_ready,
    m4m_out_if.source          o_out
);

    localparam int DIM   = m4m_pkg::DIM;
    localparam int ROW_W = m4m_pkg::ROW_W;
    localparam int IDX_W = m4m_pkg::IDX_W;

    // Left matrix banked by column, right matrix banked by row, so that one
    // product element reads each bank at a single address.
    m4m_pkg::t_data r_lmem [DIM][DIM];
    m4m_pkg::t_data r_rmem [DIM][DIM];
    logic           r_lvld [DIM][DIM];
    logic           r_rvld [DIM][DIM];

    logic             r_busy;
    logic [IDX_W-1:0] r_cnt;
    logic             adv, take;
    logic [ROW_W-1:0] wr_lo, wr_hi, rd_row, rd_col;

    logic             r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_o_v;
    logic [IDX_W-1:0] r_s1_idx, r_s2_idx, r_s3_idx, r_s4_idx, r_o_idx;
    logic             r_s1_last, r_s2_last, r_s3_last, r_s4_last, r_o_last;
    m4m_pkg::t_data   r_s1_a [DIM];
    m4m_pkg::t_data   r_s1_b [DIM];
    logic             r_s1_av [DIM];
    logic             r_s1_bv [DIM];
    m4m_pkg::t_data   op_a [DIM];
    m4m_pkg::t_data   op_b [DIM];
    logic signed [m4m_pkg::PROD_W-1:0] r_s2_p [DIM];
    logic signed [m4m_pkg::HALF_W-1:0] r_s3_h [DIM/2];
    logic signed [m4m_pkg::SUM_W-1:0]  n_s4_sum, r_s4_sum, shifted;
    m4m_pkg::t_data   n_o_val, r_o_val;

    assign adv         = !r_o_v || o_out.ready;
    assign o_cmd_ready = !r_busy;
    assign take        = i_cmd_valid && !r_busy;
    assign wr_lo       = i_cmd.index[ROW_W-1:0];
    assign wr_hi       = i_cmd.index[IDX_W-1:ROW_W];
    assign rd_row      = r_cnt[ROW_W-1:0];
    assign rd_col      = r_cnt[IDX_W-1:ROW_W];

    always_ff @(posedge i_clk) begin
        if (take && (i_cmd.action == m4m_pkg::ACT_LOAD_LEFT)) begin
            r_lmem[wr_hi][wr_lo] <= i_cmd.value;
        end
        if (take && (i_cmd.action == m4m_pkg::ACT_LOAD_RIGHT)) begin
            r_rmem[wr_lo][wr_hi] <= i_cmd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < DIM; e++) begin
                for (int k = 0; k < DIM; k++) begin
                    r_lvld[e][k] <= 1'b0;
                    r_rvld[e][k] <= 1'b0;
                end
            end
        end else begin
            if (take && (i_cmd.action == m4m_pkg::ACT_LOAD_LEFT)) begin
                r_lvld[wr_hi][wr_lo] <= 1'b1;
            end
            if (take && (i_cmd.action == m4m_pkg::ACT_LOAD_RIGHT)) begin
                r_rvld[wr_lo][wr_hi] <= 1'b1;
            end
        end
    end

    // Registered bank reads; an entry never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int e = 0; e < DIM; e++) begin
                r_s1_a[e]  <= r_lmem[e][rd_row];
                r_s1_av[e] <= r_lvld[e][rd_row];
                r_s1_b[e]  <= r_rmem[e][rd_col];
                r_s1_bv[e] <= r_rvld[e][rd_col];
            end
        end
    end

    always_comb begin
        for (int e = 0; e < DIM; e++) begin
            op_a[e] = r_s1_av[e] ? r_s1_a[e] : '0;
            op_b[e] = r_s1_bv[e] ? r_s1_b[e] : '0;
        end
    end

    always_comb begin
        n_s4_sum = m4m_pkg::ROUND_HALF;
        for (int k = 0; k < DIM/2; k++) begin
            n_s4_sum = n_s4_sum + m4m_pkg::SUM_W'(r_s3_h[k]);
        end
    end

    assign shifted = r_s4_sum >>> m4m_pkg::FRAC_W;

    always_comb begin
        if (shifted > m4m_pkg::SAT_HI) begin
            n_o_val = m4m_pkg::t_data'(m4m_pkg::SAT_HI[m4m_pkg::DATA_W-1:0]);
        end else if (shifted < m4m_pkg::SAT_LO) begin
            n_o_val = m4m_pkg::t_data'(m4m_pkg::SAT_LO[m4m_pkg::DATA_W-1:0]);
        end else begin
            n_o_val = shifted[m4m_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_idx  <= r_cnt;
            r_s1_last <= (r_cnt == m4m_pkg::LAST_IDX);
            for (int e = 0; e < DIM; e++) begin
                r_s2_p[e] <= op_a[e] * op_b[e];
            end
            r_s2_idx  <= r_s1_idx;
            r_s2_last <= r_s1_last;
            for (int k = 0; k < DIM/2; k++) begin
                r_s3_h[k] <= m4m_pkg::HALF_W'(r_s2_p[2*k]) + m4m_pkg::HALF_W'(r_s2_p[2*k+1]);
            end
            r_s3_idx  <= r_s2_idx;
            r_s3_last <= r_s2_last;
            r_s4_sum  <= n_s4_sum;
            r_s4_idx  <= r_s3_idx;
            r_s4_last <= r_s3_last;
            r_o_val   <= n_o_val;
            r_o_idx   <= r_s4_idx;
            r_o_last  <= r_s4_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (take && (i_cmd.action == m4m_pkg::ACT_COMPUTE)) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy && adv) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == m4m_pkg::LAST_IDX) begin
                    r_busy <= 1'b0;
                end
            end
            if (adv) begin
                r_s1_v <= r_busy;
                r_s2_v <= r_s1_v;
                r_s3_v <= r_s2_v;
                r_s4_v <= r_s3_v;
                r_o_v  <= r_s4_v;
            end
        end
    end

    assign o_out.valid     = r_o_v;
    assign o_out.out_index = r_o_idx;
    assign o_out.out_value = r_o_val;
    assign o_out.out_last  = r_o_last;

    `M4M_CHECK_NOW(a_last_at_end, i_clk, i_rst_n, r_o_v && r_o_last, r_o_idx == m4m_pkg::LAST_IDX)
    `M4M_CHECK_NEXT(a_issue_holds, i_clk, i_rst_n, r_busy && adv && (r_cnt != m4m_pkg::LAST_IDX), r_busy)
    `M4M_CHECK_NEXT(a_issue_ends, i_clk, i_rst_n, r_busy && adv && (r_cnt == m4m_pkg::LAST_IDX), !r_busy && r_s1_v)

endmodule

`default_nettype wire

### design/matrix4_multiply.sv
`default_nettype none
// Channel  Direction  Carries
// i_in     in         action, elem_index, elem_value (load left, load right, compute)
// o_out    out        out_index, out_value, out_last (one per product element)
//
// The back part takes a load request whenever it is not busy; a four-entry queue lets the front
// keep taking requests while it is busy. A compute request holds it busy while it issues
// sixteen elements, one per cycle unless the output stalls, through four parallel multipliers
// and an adder tree: bank read, multiply, pair add, rounded sum and saturated output registers.
// Synchronous reset empties the queue and pipeline and makes both matrices read as zero.
// A stalled output freezes the whole back pipeline; the front stalls only when the queue is full.

module matrix4_multiply (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    m4m_in_if.sink    i_in,
    m4m_out_if.source o_out
);

    m4m_pkg::t_cmd cmd;
    logic          cmd_valid, cmd_ready;

    m4m_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready)
    );

    m4m_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
